>>> src/rnrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnrb_pkg
// Register map, status bit positions and shared types of the random number
// register block.
// ----------------------------------------------------------------------------
package rnrb_pkg;

	// Number of seed and output words.
	localparam int RANDOM_WORDS = 5;
	localparam int IDX_W        = (RANDOM_WORDS > 1) ? $clog2(RANDOM_WORDS) : 1;

	localparam int OFS_W = 9;
	localparam int DAT_W = 32;
	localparam int STS_W = 6;

	localparam logic [OFS_W-1:0] OFS_CONTROL = 9'h000;
	localparam logic [OFS_W-1:0] OFS_STATUS  = 9'h010;
	localparam logic [OFS_W-1:0] OFS_SEED    = 9'h140;
	localparam logic [OFS_W-1:0] OFS_OUTPUT  = 9'h160;

	// Access kinds.
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Control bits.
	localparam int CTL_ENGINE_SEL = 3;
	localparam int CTL_START      = 4;

	// Status bits.
	localparam int ST_BUFFER_READY = 0;
	localparam int ST_SEED_DONE    = 1;
	localparam int ST_ENGINE_DONE  = 5;
	localparam logic [STS_W-1:0] ST_WRITE_MASK  = 6'h38;
	localparam logic [STS_W-1:0] ST_RESET_VALUE = 6'h01;

	typedef logic [DAT_W-1:0] word_t;

	// Register selected by one offset.
	typedef struct packed {
		logic             is_control;
		logic             is_status;
		logic             is_seed;
		logic             is_output;
		logic [IDX_W-1:0] idx;
	} decode_t;

endpackage

>>> src/rnrb_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnrb_decode
// Address decoder: maps a byte offset onto the control, status, seed and
// output registers.
// ----------------------------------------------------------------------------
module rnrb_decode (
	input  logic [rnrb_pkg::OFS_W-1:0] offset,
	output rnrb_pkg::decode_t          dec
);

	localparam int BANK_W = rnrb_pkg::OFS_W - 2;

	logic [rnrb_pkg::OFS_W-1:0] seed_d;
	logic [rnrb_pkg::OFS_W-1:0] out_d;
	logic                       seed_hit;
	logic                       out_hit;

	assign seed_d = offset - rnrb_pkg::OFS_SEED;
	assign out_d  = offset - rnrb_pkg::OFS_OUTPUT;

	// A bank hit needs the offset at or above the base, word aligned, and in range.
	assign seed_hit = (offset >= rnrb_pkg::OFS_SEED) && (seed_d[1:0] == 2'b00) &&
		(seed_d[rnrb_pkg::OFS_W-1:2] < BANK_W'(rnrb_pkg::RANDOM_WORDS));
	assign out_hit = (offset >= rnrb_pkg::OFS_OUTPUT) && (out_d[1:0] == 2'b00) &&
		(out_d[rnrb_pkg::OFS_W-1:2] < BANK_W'(rnrb_pkg::RANDOM_WORDS));

	always_comb begin
		dec.is_control = (offset == rnrb_pkg::OFS_CONTROL);
		dec.is_status  = (offset == rnrb_pkg::OFS_STATUS);
		dec.is_seed    = seed_hit;
		dec.is_output  = out_hit;
		if (seed_hit) begin
			dec.idx = seed_d[2 +: rnrb_pkg::IDX_W];
		end else begin
			dec.idx = out_d[2 +: rnrb_pkg::IDX_W];
		end
	end

endmodule

>>> src/random_number_register_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_number_register_block
// Bus register front end of a random number generator: control, status,
// seed and output word registers, with entropy loaded on an engine start.
// ----------------------------------------------------------------------------
// A request passes the input register, then the response register.
// Throughput: one request per cycle; the input register and the response
// register both advance whenever the response slot is empty or being taken.
// Reset: control and seed mask clear, status reads buffer ready, output
// words clear; no clearing pass is needed.
module random_number_register_block (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        cmd,
	input  logic [8:0]  offset,
	input  logic [31:0] write_data,
	input  logic [31:0] entropy_word_0,
	input  logic [31:0] entropy_word_1,
	input  logic [31:0] entropy_word_2,
	input  logic [31:0] entropy_word_3,
	input  logic [31:0] entropy_word_4,
	input  logic        entropy_ok,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [31:0] read_data,
	output logic        bad_offset
);

	localparam int NW = rnrb_pkg::RANDOM_WORDS;

	// Input register.
	logic                       valid_s1;
	logic                       cmd_s1;
	logic [rnrb_pkg::OFS_W-1:0] offset_s1;
	rnrb_pkg::word_t            data_s1;
	rnrb_pkg::word_t            ent_s1 [NW];
	logic                       ent_ok_s1;

	// Architectural state.
	rnrb_pkg::word_t            control_q;
	logic [rnrb_pkg::STS_W-1:0] status_q;
	logic [NW-1:0]              seed_mask_q;
	rnrb_pkg::word_t            words_q [NW];

	// Response register.
	logic                       rsp_valid_q;
	rnrb_pkg::word_t            read_data_q;
	logic                       bad_q;

	rnrb_pkg::word_t            ent_all [5];
	rnrb_pkg::decode_t          dec;
	logic                       advance;
	logic                       exec;
	logic                       is_wr;
	logic [NW-1:0]              seed_next;
	logic                       start_ok;
	rnrb_pkg::word_t            rd;
	logic                       bad;

	assign ent_all[0] = entropy_word_0;
	assign ent_all[1] = entropy_word_1;
	assign ent_all[2] = entropy_word_2;
	assign ent_all[3] = entropy_word_3;
	assign ent_all[4] = entropy_word_4;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;
	assign exec      = valid_s1 && advance;
	assign is_wr     = (cmd_s1 == rnrb_pkg::CMD_WRITE);

	rnrb_decode u_decode (
		.offset (offset_s1),
		.dec    (dec)
	);

	assign seed_next = seed_mask_q | (NW'(1) << dec.idx);

	// The engine runs only with seeding done, entropy ok, and both select and start in the new word.
	assign start_ok = status_q[rnrb_pkg::ST_SEED_DONE] &&
		data_s1[rnrb_pkg::CTL_ENGINE_SEL] && data_s1[rnrb_pkg::CTL_START] && ent_ok_s1;

	always_comb begin
		rd  = '0;
		bad = 1'b0;
		if (is_wr) begin
			bad = !(dec.is_control || dec.is_status || dec.is_seed);
		end else if (dec.is_control) begin
			rd = control_q;
		end else if (dec.is_status) begin
			rd = {{(rnrb_pkg::DAT_W - rnrb_pkg::STS_W){1'b0}}, status_q};
		end else if (dec.is_output) begin
			rd = words_q[dec.idx];
		end else begin
			bad = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			cmd_s1    <= cmd;
			offset_s1 <= offset;
			data_s1   <= write_data;
			ent_ok_s1 <= entropy_ok;
			for (int i = 0; i < NW; i++) begin
				ent_s1[i] <= ent_all[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q   <= '0;
			status_q    <= rnrb_pkg::ST_RESET_VALUE;
			seed_mask_q <= '0;
			for (int i = 0; i < NW; i++) begin
				words_q[i] <= '0;
			end
		end else if (exec && is_wr) begin
			if (dec.is_control) begin
				// The start bit is never stored.
				control_q <= data_s1 & ~(rnrb_pkg::word_t'(1) << rnrb_pkg::CTL_START);
				if (start_ok) begin
					for (int i = 0; i < NW; i++) begin
						words_q[i] <= ent_s1[i];
					end
					status_q[rnrb_pkg::ST_ENGINE_DONE] <= 1'b1;
				end
			end else if (dec.is_status) begin
				status_q <= (status_q & ~rnrb_pkg::ST_WRITE_MASK) |
					(data_s1[rnrb_pkg::STS_W-1:0] & rnrb_pkg::ST_WRITE_MASK);
			end else if (dec.is_seed) begin
				seed_mask_q <= seed_next;
				status_q[rnrb_pkg::ST_SEED_DONE] <= &seed_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			read_data_q <= rd;
			bad_q       <= bad;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_data  = read_data_q;
	assign bad_offset = bad_q;

endmodule
